[rtl/core/vds_pkg.sv]
// Shared types and constants for the velocity drag scaler.
package vds_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgResistance    = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgRestThreshold = 1'b1;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [31:0] elapsed_time;
    } t_vds_in;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               at_rest;
    } t_vds_out;

    // Control that travels down the pipeline with each request.
    typedef struct packed {
        logic vld;
        logic rest;
    } t_vds_ctl;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction
endpackage

[rtl/core/vds_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module vds_sqrt
    import vds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_sum,
    input  t_vds_in     i_item,
    output logic        o_vld,
    output logic [31:0] o_root,
    output t_vds_in     o_item
);
    localparam int Steps = 32;

    logic        r_vld  [Steps];
    logic [63:0] r_rem  [Steps];
    logic [31:0] r_root [Steps];
    t_vds_in     r_item [Steps];

    // Each stage decides one root bit, most significant first.
    genvar g;
    generate
        for (g = 0; g < Steps; g++) begin : g_stg
            logic [63:0] rem_in;
            logic [31:0] root_in;
            logic        vld_in;
            t_vds_in     item_in;
            logic [65:0] trial;
            logic [65:0] shifted;
            if (g == 0) begin : g_first
                assign rem_in  = i_sum;
                assign root_in = '0;
                assign vld_in  = i_vld;
                assign item_in = i_item;
            end else begin : g_rest
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
                assign vld_in  = r_vld[g-1];
                assign item_in = r_item[g-1];
            end
            // Compare remainder's top bits with 4*root+1 aligned at this bit pair.
            assign shifted = {2'b00, rem_in} >> (2 * (Steps - 1 - g));
            assign trial   = {32'd0, root_in, 2'b01};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= vld_in;
                end
                r_item[g] <= item_in;
                if (shifted >= trial) begin
                    r_rem[g]  <= rem_in - 64'(trial << (2 * (Steps - 1 - g)));
                    r_root[g] <= {root_in[30:0], 1'b1};
                end else begin
                    r_rem[g]  <= rem_in;
                    r_root[g] <= {root_in[30:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[Steps-1];
    assign o_root = r_root[Steps-1];
    assign o_item = r_item[Steps-1];
endmodule

[rtl/core/vds_div.sv]
// Pipelined restoring divider: 64-bit numerator by 32-bit divisor, one bit per stage.
module vds_div
    import vds_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [63:0] o_quo
);
    localparam int Steps = 64;

    logic [63:0] r_num [Steps];
    logic [32:0] r_rem [Steps];
    logic [31:0] r_den [Steps];

    genvar g;
    generate
        for (g = 0; g < Steps; g++) begin : g_stg
            logic [63:0] num_in;
            logic [32:0] rem_in;
            logic [31:0] den_in;
            logic [33:0] part;
            if (g == 0) begin : g_first
                assign num_in = i_num;
                assign rem_in = '0;
                assign den_in = i_den;
            end else begin : g_rest
                assign num_in = r_num[g-1];
                assign rem_in = r_rem[g-1];
                assign den_in = r_den[g-1];
            end
            assign part = {rem_in, num_in[63]};
            // The quotient bit is shifted into the numerator's vacated low end.
            always_ff @(posedge i_clk) begin
                r_den[g] <= den_in;
                if (part >= {2'b00, den_in}) begin
                    r_rem[g] <= 33'(part - {2'b00, den_in});
                    r_num[g] <= {num_in[62:0], 1'b1};
                end else begin
                    r_rem[g] <= part[32:0];
                    r_num[g] <= {num_in[62:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_quo = r_num[Steps-1];
endmodule

[rtl/core/velocity_drag_scaler.sv]
// Top level of the velocity drag scaler.
// Usage: raise start with a request on i_in while busy is low; busy is
// always low, so a request may enter on every cycle. Each request produces one
// result on o_out, marked by o_done for one cycle, in request order.
// The pipeline has a squaring and a summing stage, 32 square-root stages (one
// root bit each), drag product, clamp and numerator multiply, 64 divider
// stages (one quotient bit each), and the output register. Throughput is one
// request per cycle; bit-serial square root and divider stages set the latency.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while no request is in flight, which the block does not
// enforce. An index beyond the list is ignored.
// Reset clears all valid bits, sets resistance to 0 and the rest threshold to 1.
// Results cannot be held off by the receiver.
module velocity_drag_scaler
    import vds_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_vds_in            i_in,
    output logic               o_done,
    output t_vds_out           o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    localparam int DivLat = 64;

    logic [31:0] r_res;
    logic [15:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
            r_thr <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgResistance:    r_res <= i_cfg_data;
                CfgRestThreshold: r_thr <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: squares. Stage 2: sum.
    logic        r_s1_vld, r_s2_vld;
    t_vds_in     r_s1_item, r_s2_item;
    logic [63:0] r_s1_sx, r_s1_sy, r_s1_sz, r_s2_sum;
    logic [31:0] mx, my, mz;
    assign mx = mag32(i_in.vel_x);
    assign my = mag32(i_in.vel_y);
    assign mz = mag32(i_in.vel_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_item <= i_in;
        r_s1_sx   <= 64'(mx) * 64'(mx);
        r_s1_sy   <= 64'(my) * 64'(my);
        r_s1_sz   <= 64'(mz) * 64'(mz);
        r_s2_item <= r_s1_item;
        r_s2_sum  <= r_s1_sx + r_s1_sy + r_s1_sz;
    end

    logic        sq_vld;
    logic [31:0] sq_root;
    t_vds_in     sq_item;

    vds_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s2_vld),
        .i_sum  (r_s2_sum),
        .i_item (r_s2_item),
        .o_vld  (sq_vld),
        .o_root (sq_root),
        .o_item (sq_item)
    );

    // Stage A: drag product and rest test.
    t_vds_ctl    r_a_ctl, r_b_ctl, r_c_ctl;
    t_vds_in     r_a_item, r_b_item, r_c_item;
    logic [31:0] r_a_spd, r_b_spd, r_b_nspd, r_c_spd;
    logic [63:0] r_a_prod;
    logic [63:0] drag_sh;
    logic [31:0] drag;
    logic [63:0] r_c_nx, r_c_ny, r_c_nz;
    assign drag_sh = r_a_prod >> FRAC_BITS;
    assign drag    = (drag_sh[63:32] != '0) ? 32'hFFFF_FFFF : drag_sh[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
        end else begin
            r_a_ctl <= '{vld: sq_vld, rest: ({16'd0, r_thr} >= sq_root)};
            r_b_ctl <= r_a_ctl;
            r_c_ctl <= r_b_ctl;
        end
        r_a_item <= sq_item;
        r_a_spd  <= sq_root;
        r_a_prod <= 64'(sq_item.elapsed_time) * 64'(r_res);
        // Stage B: clamp the new speed.
        r_b_item <= r_a_item;
        r_b_spd  <= r_a_spd;
        r_b_nspd <= (r_a_spd > drag) ? r_a_spd - drag : 32'd0;
        // Stage C: numerators.
        r_c_item <= r_b_item;
        r_c_spd  <= r_b_spd;
        r_c_nx   <= 64'(mag32(r_b_item.vel_x)) * 64'(r_b_nspd);
        r_c_ny   <= 64'(mag32(r_b_item.vel_y)) * 64'(r_b_nspd);
        r_c_nz   <= 64'(mag32(r_b_item.vel_z)) * 64'(r_b_nspd);
    end

    logic [63:0] qx, qy, qz;
    vds_div u_div_x (.i_clk(i_clk), .i_num(r_c_nx), .i_den(r_c_spd), .o_quo(qx));
    vds_div u_div_y (.i_clk(i_clk), .i_num(r_c_ny), .i_den(r_c_spd), .o_quo(qy));
    vds_div u_div_z (.i_clk(i_clk), .i_num(r_c_nz), .i_den(r_c_spd), .o_quo(qz));

    // Control and item follow the divider in step.
    t_vds_ctl r_dctl  [DivLat];
    t_vds_in  r_ditem [DivLat];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivLat; k++) r_dctl[k] <= '0;
        end else begin
            r_dctl[0] <= r_c_ctl;
            for (int k = 1; k < DivLat; k++) r_dctl[k] <= r_dctl[k-1];
        end
        r_ditem[0] <= r_c_item;
        for (int k = 1; k < DivLat; k++) r_ditem[k] <= r_ditem[k-1];
    end

    t_vds_in  d_item;
    t_vds_ctl d_ctl;
    assign d_item = r_ditem[DivLat-1];
    assign d_ctl  = r_dctl[DivLat-1];

    function automatic logic [31:0] apply_sign(input logic neg, input logic [63:0] q);
        apply_sign = neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    logic     r_done;
    t_vds_out r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_ctl.vld;
        end
        if (d_ctl.rest) begin
            r_out <= '{new_vel_x: d_item.vel_x, new_vel_y: d_item.vel_y,
                       new_vel_z: d_item.vel_z, at_rest: 1'b1};
        end else begin
            r_out <= '{new_vel_x: apply_sign(d_item.vel_x[31], qx),
                       new_vel_y: apply_sign(d_item.vel_y[31], qy),
                       new_vel_z: apply_sign(d_item.vel_z[31], qz),
                       at_rest: 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;
endmodule

[rtl/core/vds_checker.sv]
// Port-level checker for the velocity drag scaler, bound to the top level.
module vds_checker
    import vds_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_done,
    input t_vds_out o_out
);
    localparam int Lat = 102;

    // Every accepted request yields a result strobe on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Lat o_done) else $error("result missing");

    // No result appears without a matching request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, Lat)) else $error("unexpected result");

    // The pipeline takes a request on every cycle, so it never reports busy.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    // Reset silences the result strobe in the following cycle.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done) else $error("strobe after reset");
endmodule

bind velocity_drag_scaler vds_checker u_vds_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_done (o_done),
    .o_out  (o_out)
);
